@@ rtl/rvx_pkg.sv @@
package rvx_pkg;

   localparam int XLEN        = 32;
   localparam int REG_COUNT   = 32;
   localparam int REG_IDX_W   = 5;
   localparam int CSR_ADDR_W  = 3;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 72;

   localparam logic [CSR_ADDR_W-1:0] CSR_TEXT_BASE    = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STACK_INIT   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_DATA_BASE    = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PRINT_CALL   = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_READ_CALL    = 3'd4;

   localparam logic [XLEN-1:0] PRINT_CALL_RESET = 32'd1;
   localparam logic [XLEN-1:0] READ_CALL_RESET  = 32'd5;

   localparam logic [REG_IDX_W-1:0] REG_ZERO = 5'd0;
   localparam logic [REG_IDX_W-1:0] REG_SP   = 5'd2;
   localparam logic [REG_IDX_W-1:0] REG_GP   = 5'd3;
   localparam logic [REG_IDX_W-1:0] REG_A0   = 5'd10;
   localparam logic [REG_IDX_W-1:0] REG_A1   = 5'd11;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OP_IMM = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_FENCE  = 7'h0F;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;
   localparam logic [2:0] F3_BGEU = 3'd7;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_SUB  = 7'h20;

   localparam logic [XLEN-1:0] ECALL_WORD = 32'h0000_0073;

   typedef enum logic [3:0] {
      OP_RESTART,
      OP_ADD,
      OP_SUB,
      OP_XOR,
      OP_ADDI,
      OP_SLLI,
      OP_LUI,
      OP_AUIPC,
      OP_JAL,
      OP_JALR,
      OP_BRANCH,
      OP_ECALL,
      OP_NOP,
      OP_STOP
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [REG_IDX_W-1:0]  rd;
      logic [REG_IDX_W-1:0]  rs1;
      logic [REG_IDX_W-1:0]  rs2;
      logic [2:0]            funct3;
      logic [XLEN-1:0]       imm;
      logic [XLEN-1:0]       host_value;
   } uop_type;

endpackage

@@ rtl/rvx_ram.sv @@
module rvx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_a <= mem_ff[raddr_a];
         rdata_b <= mem_ff[raddr_b];
      end
   end

endmodule

@@ rtl/rvx_front.sv @@
module rvx_front (
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,
   input  logic [rvx_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            push_valid,
   input  logic                            push_ready,
   output rvx_pkg::uop_type                push_uop
);

   import rvx_pkg::*;

   logic [XLEN-1:0] word;
   logic [6:0]      opcode;
   logic [6:0]      funct7;
   logic [XLEN-1:0] imm_i;
   logic [XLEN-1:0] imm_u;
   logic [XLEN-1:0] imm_j;
   logic [XLEN-1:0] imm_b;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;

   assign word   = req_tdata[XLEN-1:0];
   assign opcode = word[6:0];
   assign funct7 = word[31:25];
   assign imm_i  = {{20{word[31]}}, word[31:20]};
   assign imm_u  = {word[31:12], 12'd0};
   assign imm_j  = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
   assign imm_b  = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};

   always_comb begin
      push_uop.op         = OP_STOP;
      push_uop.rd         = word[11:7];
      push_uop.rs1        = word[19:15];
      push_uop.rs2        = word[24:20];
      push_uop.funct3     = word[14:12];
      push_uop.imm        = imm_i;
      push_uop.host_value = req_tdata[REQ_TDATA_W-1:XLEN];
      if (req_tuser) begin
         push_uop.op = OP_RESTART;
      end else begin
         case (opcode)
            OPC_OP: begin
               if (push_uop.funct3 == F3_ADD && funct7 == F7_BASE) begin
                  push_uop.op = OP_ADD;
               end else if (push_uop.funct3 == F3_ADD && funct7 == F7_SUB) begin
                  push_uop.op = OP_SUB;
               end else if (push_uop.funct3 == F3_XOR && funct7 == F7_BASE) begin
                  push_uop.op = OP_XOR;
               end
            end
            OPC_OP_IMM: begin
               if (push_uop.funct3 == F3_ADD) begin
                  push_uop.op = OP_ADDI;
               end else if (push_uop.funct3 == F3_SLL && funct7 == F7_BASE) begin
                  push_uop.op = OP_SLLI;
               end
            end
            OPC_LOAD, OPC_STORE, OPC_FENCE: begin
               push_uop.op = OP_NOP;
            end
            OPC_LUI: begin
               push_uop.op  = OP_LUI;
               push_uop.imm = imm_u;
            end
            OPC_AUIPC: begin
               push_uop.op  = OP_AUIPC;
               push_uop.imm = imm_u;
            end
            OPC_JAL: begin
               push_uop.op  = OP_JAL;
               push_uop.imm = imm_j;
            end
            OPC_JALR: begin
               if (push_uop.funct3 == F3_ADD) begin
                  push_uop.op = OP_JALR;
               end
            end
            OPC_BRANCH: begin
               push_uop.imm = imm_b;
               if (!(push_uop.funct3 inside {3'd2, 3'd3})) begin
                  push_uop.op = OP_BRANCH;
               end
            end
            OPC_SYSTEM: begin
               if (word == ECALL_WORD) begin
                  // The call id sits in a0 and the argument in a1.
                  push_uop.op  = OP_ECALL;
                  push_uop.rs1 = REG_A0;
                  push_uop.rs2 = REG_A1;
                  push_uop.rd  = REG_A1;
               end
            end
            default: begin
               push_uop.op = OP_STOP;
            end
         endcase
      end
   end

endmodule

@@ rtl/rvx_queue.sv @@
module rvx_queue #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  rvx_pkg::uop_type push_uop,
   input  logic             pop,
   output logic             head_valid,
   output rvx_pkg::uop_type head_uop
);

   import rvx_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   uop_type         slot_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            do_push;
   logic            do_pop;

   assign push_ready = count_ff != CW'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head_uop   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_uop;
      end
   end

endmodule

@@ rtl/rvx_back.sv @@
module rvx_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rvx_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [rvx_pkg::XLEN-1:0]        csr_wdata,
   input  logic                            q_valid,
   input  rvx_pkg::uop_type                q_uop,
   output logic                            q_pop,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rvx_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import rvx_pkg::*;

   logic [XLEN-1:0]      text_base_ff;
   logic [XLEN-1:0]      stack_init_ff;
   logic [XLEN-1:0]      data_base_ff;
   logic [XLEN-1:0]      print_id_ff;
   logic [XLEN-1:0]      read_id_ff;

   logic [XLEN-1:0]      pc_ff;
   logic [XLEN-1:0]      pc_in;
   logic [XLEN-1:0]      sp_init_ff;
   logic [XLEN-1:0]      gp_init_ff;
   logic [REG_COUNT-1:0] written_ff;

   logic                 x1_valid_ff;
   logic                 x1_valid_in;
   uop_type              x1_uop_ff;
   logic                 fwd_a_ff;
   logic                 fwd_a_in;
   logic                 fwd_b_ff;
   logic                 fwd_b_in;
   logic [XLEN-1:0]      fwd_data_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   logic                 fire;
   logic                 advance;
   logic [XLEN-1:0]      rdata_a;
   logic [XLEN-1:0]      rdata_b;
   logic [XLEN-1:0]      op_a;
   logic [XLEN-1:0]      op_b;
   logic [XLEN-1:0]      link;
   logic [XLEN-1:0]      next_pc;
   logic [XLEN-1:0]      wr_data;
   logic                 wr_req;
   logic                 wr_en;
   logic                 take_branch;
   logic                 stop;
   logic                 print_valid;
   logic [XLEN-1:0]      print_value;
   logic                 value_taken;

   function automatic logic [XLEN-1:0] reg_default(input logic [REG_IDX_W-1:0] idx,
                                                   input logic [XLEN-1:0] sp,
                                                   input logic [XLEN-1:0] gp);
      logic [XLEN-1:0] v;
      v = '0;
      if (idx == REG_SP) begin
         v = sp;
      end else if (idx == REG_GP) begin
         v = gp;
      end
      return v;
   endfunction

   assign fire    = x1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign advance = !x1_valid_ff || fire;
   assign q_pop   = advance && q_valid;

   rvx_ram #(
      .WIDTH (XLEN),
      .DEPTH (REG_COUNT)
   ) u_regfile (
      .clock   (clock),
      .we      (fire && wr_en),
      .waddr   (x1_uop_ff.rd),
      .wdata   (wr_data),
      .re      (q_pop),
      .raddr_a (q_uop.rs1),
      .raddr_b (q_uop.rs2),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
   );

   always_comb begin
      if (fwd_a_ff) begin
         op_a = fwd_data_ff;
      end else if (written_ff[x1_uop_ff.rs1]) begin
         op_a = rdata_a;
      end else begin
         op_a = reg_default(x1_uop_ff.rs1, sp_init_ff, gp_init_ff);
      end
      if (fwd_b_ff) begin
         op_b = fwd_data_ff;
      end else if (written_ff[x1_uop_ff.rs2]) begin
         op_b = rdata_b;
      end else begin
         op_b = reg_default(x1_uop_ff.rs2, sp_init_ff, gp_init_ff);
      end
   end

   always_comb begin
      case (x1_uop_ff.funct3)
         F3_BEQ:  take_branch = op_a == op_b;
         F3_BNE:  take_branch = op_a != op_b;
         F3_BLT:  take_branch = $signed(op_a) < $signed(op_b);
         F3_BGE:  take_branch = $signed(op_a) >= $signed(op_b);
         F3_BLTU: take_branch = op_a < op_b;
         F3_BGEU: take_branch = op_a >= op_b;
         default: take_branch = 1'b0;
      endcase
   end

   always_comb begin
      link        = pc_ff + 32'd4;
      next_pc     = link;
      wr_data     = link;
      wr_req      = 1'b0;
      stop        = 1'b0;
      print_valid = 1'b0;
      print_value = '0;
      value_taken = 1'b0;
      case (x1_uop_ff.op)
         OP_RESTART: begin
            next_pc = text_base_ff;
         end
         OP_ADD: begin
            wr_req  = 1'b1;
            wr_data = op_a + op_b;
         end
         OP_SUB: begin
            wr_req  = 1'b1;
            wr_data = op_a - op_b;
         end
         OP_XOR: begin
            wr_req  = 1'b1;
            wr_data = op_a ^ op_b;
         end
         OP_ADDI: begin
            wr_req  = 1'b1;
            wr_data = op_a + x1_uop_ff.imm;
         end
         OP_SLLI: begin
            wr_req  = 1'b1;
            wr_data = op_a << x1_uop_ff.rs2;
         end
         OP_LUI: begin
            wr_req  = 1'b1;
            wr_data = x1_uop_ff.imm;
         end
         OP_AUIPC: begin
            wr_req  = 1'b1;
            wr_data = x1_uop_ff.imm + pc_ff;
         end
         OP_JAL: begin
            wr_req  = 1'b1;
            next_pc = pc_ff + x1_uop_ff.imm;
         end
         OP_JALR: begin
            wr_req  = 1'b1;
            next_pc = (op_a + x1_uop_ff.imm) & ~32'd1;
         end
         OP_BRANCH: begin
            if (take_branch) begin
               next_pc = pc_ff + x1_uop_ff.imm;
            end
         end
         OP_ECALL: begin
            if (op_a == print_id_ff) begin
               print_valid = 1'b1;
               print_value = op_b;
            end else if (op_a == read_id_ff) begin
               wr_req      = 1'b1;
               wr_data     = x1_uop_ff.host_value;
               value_taken = 1'b1;
            end else begin
               stop = 1'b1;
            end
         end
         OP_NOP: begin
            stop = 1'b0;
         end
         default: begin
            stop = 1'b1;
         end
      endcase
      wr_en = wr_req && (x1_uop_ff.rd != REG_ZERO);
   end

   always_comb begin
      pc_in = fire ? next_pc : pc_ff;

      x1_valid_in = x1_valid_ff;
      if (q_pop) begin
         x1_valid_in = 1'b1;
      end else if (fire) begin
         x1_valid_in = 1'b0;
      end

      // A write leaving the execute stage is not yet visible in the read data.
      fwd_a_in = fire && wr_en && (q_uop.rs1 == x1_uop_ff.rd);
      fwd_b_in = fire && wr_en && (q_uop.rs2 == x1_uop_ff.rd);

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in = {5'd0, value_taken, print_value, print_valid, stop, next_pc};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_base_ff  <= '0;
         stack_init_ff <= '0;
         data_base_ff  <= '0;
         print_id_ff   <= PRINT_CALL_RESET;
         read_id_ff    <= READ_CALL_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_TEXT_BASE:  text_base_ff  <= csr_wdata;
            CSR_STACK_INIT: stack_init_ff <= csr_wdata;
            CSR_DATA_BASE:  data_base_ff  <= csr_wdata;
            CSR_PRINT_CALL: print_id_ff   <= csr_wdata;
            CSR_READ_CALL:  read_id_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         sp_init_ff   <= '0;
         gp_init_ff   <= '0;
         written_ff   <= '0;
         x1_valid_ff  <= 1'b0;
         fwd_a_ff     <= 1'b0;
         fwd_b_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         x1_valid_ff  <= x1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            fwd_a_ff <= fwd_a_in;
            fwd_b_ff <= fwd_b_in;
         end
         if (fire && x1_uop_ff.op == OP_RESTART) begin
            written_ff <= '0;
            sp_init_ff <= stack_init_ff;
            gp_init_ff <= data_base_ff;
         end else if (fire && wr_en) begin
            written_ff[x1_uop_ff.rd] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         x1_uop_ff   <= q_uop;
         fwd_data_ff <= wr_data;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ rtl/rv32i_subset_execute_core.sv @@
// A word goes from the queue to the execute stage register, then to the output register.
// Throughput: one word per cycle while the output is not stalled; the register file read is
// registered and a write still in flight is forwarded to the following word.
// Reset is synchronous and active high: the pc and the registers read as zero,
// the call ids return to 1 and 5, and the queue and output are empty.
module rv32i_subset_execute_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [rvx_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [rvx_pkg::XLEN-1:0]        csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // func
   input  logic                            req_tuser,
   // instr_word [31:0], host_value [63:32]
   input  logic [rvx_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // next_pc [31:0], status [32], print_valid [33], print_value [65:34],
   // value_taken [66], zero [71:67]
   output logic [rvx_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import rvx_pkg::*;

   logic    push_valid;
   logic    push_ready;
   uop_type push_uop;
   logic    head_valid;
   uop_type head_uop;
   logic    pop;

   rvx_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_uop   (push_uop)
   );

   rvx_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_uop   (push_uop),
      .pop        (pop),
      .head_valid (head_valid),
      .head_uop   (head_uop)
   );

   rvx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .q_valid    (head_valid),
      .q_uop      (head_uop),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ rtl/rvx_checker.sv @@
module rvx_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rvx_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   import rvx_pkg::*;

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_call_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[33] && rsp_tdata[66]))
      else $error("print and read reported by the same word");

   a_stop_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[32] |-> !rsp_tdata[33] && !rsp_tdata[66]
                                      && rsp_tdata[65:34] == '0)
      else $error("stopped word reports a call");

endmodule

bind rv32i_subset_execute_core rvx_checker u_checker (.*);

@@ dv/rv32i_subset_execute_core_tb.sv @@
module rv32i_subset_execute_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rvx_pkg::*;

   typedef struct packed {
      logic        func;
      logic [31:0] instr;
      logic [31:0] host;
   } core_word_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        status;
      logic        print_valid;
      logic [31:0] print_value;
      logic        value_taken;
   } core_result_type;

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [XLEN-1:0]        csr_wdata = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic                   req_tuser = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   rv32i_subset_execute_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   core_word_type   pending_words[$];
   core_result_type expected_results[$];

   logic [31:0] gpr [32];
   logic [31:0] pc_now;
   logic [31:0] text_base_cfg;
   logic [31:0] stack_init_cfg;
   logic [31:0] data_base_cfg;
   logic [31:0] print_id_cfg;
   logic [31:0] read_id_cfg;

   int  error_count = 0;
   int  results_seen = 0;
   int  words_queued = 0;
   int  restart_count = 0;
   int  print_count = 0;
   int  read_count = 0;
   int  stop_count = 0;
   int  send_gap = 0;
   int  stall_left = 0;
   int  settings_used = 1;
   bit  quiet = 1'b0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [4:0] pick_reg();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return 5'($urandom_range(10, 11));
      if (r < 38) return REG_ZERO;
      return 5'($urandom_range(0, 31));
   endfunction

   function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2, rs1,
                                         input logic [2:0] f3, input logic [4:0] rd,
                                         input logic [6:0] opc);
      return {f7, rs2, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                         input logic [2:0] f3, input logic [4:0] rd,
                                         input logic [6:0] opc);
      return {imm, rs1, f3, rd, opc};
   endfunction

   function automatic logic [31:0] enc_u(input logic [19:0] imm, input logic [4:0] rd,
                                         input logic [6:0] opc);
      return {imm, rd, opc};
   endfunction

   function automatic logic [31:0] enc_b(input logic [12:0] imm, input logic [4:0] rs2, rs1,
                                         input logic [2:0] f3);
      return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BRANCH};
   endfunction

   function automatic logic [31:0] enc_j(input logic [20:0] imm, input logic [4:0] rd);
      return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OPC_JAL};
   endfunction

   function automatic void write_gpr(input logic [4:0] idx, input logic [31:0] value);
      if (idx != REG_ZERO) gpr[idx] = value;
   endfunction

   function automatic core_result_type execute_word(input core_word_type wd);
      logic [31:0]     w, pc, a, b, immi, jimm, bimm, id;
      logic [6:0]      opc, f7;
      logic [4:0]      rd, rs1, rs2;
      logic [2:0]      f3;
      logic            take;
      core_result_type r;
      r = '0;
      if (wd.func) begin
         for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
         gpr[REG_SP] = stack_init_cfg;
         gpr[REG_GP] = data_base_cfg;
         pc_now = text_base_cfg;
         r.next_pc = pc_now;
         return r;
      end
      w    = wd.instr;
      pc   = pc_now;
      opc  = w[6:0];
      rd   = w[11:7];
      f3   = w[14:12];
      rs1  = w[19:15];
      rs2  = w[24:20];
      f7   = w[31:25];
      a    = gpr[rs1];
      b    = gpr[rs2];
      immi = {{20{w[31]}}, w[31:20]};
      jimm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      bimm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      take = 1'b0;
      r.next_pc = pc + 32'd4;
      case (opc)
         OPC_OP: begin
            if (f3 == F3_ADD && f7 == F7_BASE) write_gpr(rd, a + b);
            else if (f3 == F3_ADD && f7 == F7_SUB) write_gpr(rd, a - b);
            else if (f3 == F3_XOR && f7 == F7_BASE) write_gpr(rd, a ^ b);
            else r.status = 1'b1;
         end
         OPC_OP_IMM: begin
            if (f3 == F3_ADD) write_gpr(rd, a + immi);
            else if (f3 == F3_SLL && f7 == F7_BASE) write_gpr(rd, a << rs2);
            else r.status = 1'b1;
         end
         OPC_LOAD, OPC_STORE, OPC_FENCE: begin
         end
         OPC_LUI: write_gpr(rd, {w[31:12], 12'h000});
         OPC_AUIPC: write_gpr(rd, {w[31:12], 12'h000} + pc);
         OPC_JAL: begin
            r.next_pc = pc + jimm;
            write_gpr(rd, pc + 32'd4);
         end
         OPC_JALR: begin
            if (f3 == F3_ADD) begin
               r.next_pc = (a + immi) & ~32'd1;
               write_gpr(rd, pc + 32'd4);
            end else begin
               r.status = 1'b1;
            end
         end
         OPC_BRANCH: begin
            case (f3)
               F3_BEQ:  take = (a == b);
               F3_BNE:  take = (a != b);
               F3_BLT:  take = ($signed(a) < $signed(b));
               F3_BGE:  take = ($signed(a) >= $signed(b));
               F3_BLTU: take = (a < b);
               F3_BGEU: take = (a >= b);
               default: r.status = 1'b1;
            endcase
            if (take) r.next_pc = pc + bimm;
         end
         OPC_SYSTEM: begin
            if (w == ECALL_WORD) begin
               id = gpr[REG_A0];
               if (id == print_id_cfg) begin
                  r.print_valid = 1'b1;
                  r.print_value = gpr[REG_A1];
               end else if (id == read_id_cfg) begin
                  write_gpr(REG_A1, wd.host);
                  r.value_taken = 1'b1;
               end else begin
                  r.status = 1'b1;
               end
            end else begin
               r.status = 1'b1;
            end
         end
         default: r.status = 1'b1;
      endcase
      pc_now = r.next_pc;
      return r;
   endfunction

   task automatic queue_word(input logic func, input logic [31:0] instr);
      core_word_type wd;
      wd.func  = func;
      wd.instr = instr;
      wd.host  = $urandom;
      pending_words.push_back(wd);
      words_queued++;
   endtask

   // Loads a0 with a call id (print, read or arbitrary), sometimes a1, then calls.
   task automatic queue_call(input int kind);
      logic [31:0] id, hi, v;
      case (kind)
         0:       id = print_id_cfg;
         1:       id = read_id_cfg;
         default: id = $urandom;
      endcase
      hi = (id + 32'h800) & 32'hFFFF_F000;
      queue_word(1'b0, enc_u(hi[31:12], REG_A0, OPC_LUI));
      queue_word(1'b0, enc_i(id[11:0], REG_A0, F3_ADD, REG_A0, OPC_OP_IMM));
      if ($urandom_range(0, 1) == 0) begin
         v = $urandom;
         queue_word(1'b0, enc_u(v[31:12], REG_A1, OPC_LUI));
         queue_word(1'b0, enc_i(v[11:0], REG_A1, F3_ADD, REG_A1, OPC_OP_IMM));
      end
      queue_word(1'b0, ECALL_WORD);
   endtask

   function automatic logic [31:0] random_instr();
      logic [31:0] raw;
      logic [4:0]  rd, rs1, rs2;
      logic [2:0]  f3;
      int          sel;
      raw = $urandom;
      rd  = pick_reg();
      rs1 = pick_reg();
      rs2 = pick_reg();
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
         case ($urandom_range(0, 3))
            0:       return enc_r(F7_BASE, rs2, rs1, F3_ADD, rd, OPC_OP);
            1:       return enc_r(F7_SUB, rs2, rs1, F3_ADD, rd, OPC_OP);
            2:       return enc_r(F7_BASE, rs2, rs1, F3_XOR, rd, OPC_OP);
            default: return {raw[31:25], rs2, rs1, raw[14:12], rd, OPC_OP};
         endcase
      end
      if (sel < 24) return enc_i(raw[31:20], rs1, F3_ADD, rd, OPC_OP_IMM);
      if (sel < 30) begin
         if ($urandom_range(0, 4) == 0)
            return {raw[31:25], rs2, rs1, raw[14:12], rd, OPC_OP_IMM};
         return enc_r(F7_BASE, raw[24:20], rs1, F3_SLL, rd, OPC_OP_IMM);
      end
      if (sel < 40) return enc_u(raw[31:12], rd, OPC_LUI);
      if (sel < 45) return enc_u(raw[31:12], rd, OPC_AUIPC);
      if (sel < 52) return enc_j(raw[20:0], rd);
      if (sel < 57) begin
         f3 = ($urandom_range(0, 5) == 0) ? raw[14:12] : F3_ADD;
         return enc_i(raw[31:20], rs1, f3, rd, OPC_JALR);
      end
      if (sel < 72) begin
         case ($urandom_range(0, 6))
            0:       f3 = F3_BEQ;
            1:       f3 = F3_BNE;
            2:       f3 = F3_BLT;
            3:       f3 = F3_BGE;
            4:       f3 = F3_BLTU;
            5:       f3 = F3_BGEU;
            default: f3 = 3'($urandom_range(2, 3));
         endcase
         return enc_b(raw[12:0], rs2, rs1, f3);
      end
      if (sel < 78) begin
         case ($urandom_range(0, 2))
            0:       return {raw[31:7], OPC_LOAD};
            1:       return {raw[31:7], OPC_STORE};
            default: return {raw[31:7], OPC_FENCE};
         endcase
      end
      if (sel < 84) return ECALL_WORD;
      if (sel < 90) return {raw[31:7], OPC_SYSTEM};
      return raw;
   endfunction

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_TEXT_BASE:  text_base_cfg  = value;
         CSR_STACK_INIT: stack_init_cfg = value;
         CSR_DATA_BASE:  data_base_cfg  = value;
         CSR_PRINT_CALL: print_id_cfg   = value;
         CSR_READ_CALL:  read_id_cfg    = value;
         default: ;
      endcase
   endtask

   task automatic apply_setting(input int k);
      logic [31:0] same_id;
      same_id = $urandom_range(0, 15);
      case (k)
         1: begin
            write_csr(CSR_TEXT_BASE, '0);
            write_csr(CSR_STACK_INIT, '0);
            write_csr(CSR_DATA_BASE, '0);
            write_csr(CSR_PRINT_CALL, '0);
            write_csr(CSR_READ_CALL, '0);
         end
         2: begin
            write_csr(CSR_TEXT_BASE, '1);
            write_csr(CSR_STACK_INIT, '1);
            write_csr(CSR_DATA_BASE, '1);
            write_csr(CSR_PRINT_CALL, '1);
            write_csr(CSR_READ_CALL, 32'hFFFF_FFFE);
         end
         3: begin
            write_csr(CSR_TEXT_BASE, $urandom);
            write_csr(CSR_STACK_INIT, $urandom);
            write_csr(CSR_DATA_BASE, $urandom);
            write_csr(CSR_PRINT_CALL, same_id);
            write_csr(CSR_READ_CALL, same_id);
         end
         default: begin
            write_csr(CSR_TEXT_BASE, $urandom);
            write_csr(CSR_STACK_INIT, $urandom);
            write_csr(CSR_DATA_BASE, $urandom);
            write_csr(CSR_PRINT_CALL, $urandom);
            write_csr(CSR_READ_CALL, $urandom);
         end
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_tvalid || expected_results.size() != 0);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= 50)
         $display("MISMATCH %s on result %0d: got %h, wanted %h",
                  what, results_seen, got, want);
   endtask

   always @(posedge clock) begin : driver
      core_word_type head;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= send_gap - 1;
         end else if (pending_words.size() != 0) begin
            head = pending_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= head.func;
            req_tdata  <= {head.host, head.instr};
            send_gap   <= pick_gap();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 25) stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin : monitor
      core_word_type   taken_word;
      core_result_type due;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            taken_word.func  = req_tuser;
            taken_word.instr = req_tdata[31:0];
            taken_word.host  = req_tdata[63:32];
            expected_results.push_back(execute_word(taken_word));
            if (req_tuser) restart_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing pending", rsp_tdata[31:0], '0);
            end else begin
               due = expected_results.pop_front();
               if (due.print_valid) print_count++;
               if (due.value_taken) read_count++;
               if (due.status) stop_count++;
               if (rsp_tdata[31:0] !== due.next_pc)
                  report_mismatch("next_pc", rsp_tdata[31:0], due.next_pc);
               if (rsp_tdata[32] !== due.status)
                  report_mismatch("status", 32'(rsp_tdata[32]), 32'(due.status));
               if (rsp_tdata[33] !== due.print_valid)
                  report_mismatch("print_valid", 32'(rsp_tdata[33]), 32'(due.print_valid));
               if (rsp_tdata[65:34] !== due.print_value)
                  report_mismatch("print_value", rsp_tdata[65:34], due.print_value);
               if (rsp_tdata[66] !== due.value_taken)
                  report_mismatch("value_taken", 32'(rsp_tdata[66]), 32'(due.value_taken));
               if (rsp_tdata[71:67] !== '0)
                  report_mismatch("padding", 32'(rsp_tdata[71:67]), '0);
            end
         end
      end
   end

   initial begin : stimulus
      int start;
      for (int i = 0; i < REG_COUNT; i++) gpr[i] = '0;
      pc_now         = '0;
      text_base_cfg  = '0;
      stack_init_cfg = '0;
      data_base_cfg  = '0;
      print_id_cfg   = PRINT_CALL_RESET;
      read_id_cfg    = READ_CALL_RESET;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset values of the call ids are in force here.
      queue_word(1'b0, enc_i(12'hFFF, REG_ZERO, F3_ADD, 5'd1, OPC_OP_IMM));
      queue_word(1'b0, enc_u(20'h80000, REG_A1, OPC_LUI));
      queue_word(1'b0, enc_i(12'd1, REG_ZERO, F3_ADD, REG_A0, OPC_OP_IMM));
      queue_word(1'b0, ECALL_WORD);
      queue_word(1'b0, enc_i(12'd5, REG_ZERO, F3_ADD, REG_A0, OPC_OP_IMM));
      queue_word(1'b0, ECALL_WORD);
      queue_word(1'b0, enc_r(F7_BASE, REG_A1, 5'd1, F3_ADD, 5'd5, OPC_OP));
      queue_word(1'b0, enc_r(F7_SUB, 5'd1, REG_ZERO, F3_ADD, 5'd6, OPC_OP));
      queue_word(1'b0, enc_r(F7_BASE, 5'd6, 5'd1, F3_XOR, 5'd7, OPC_OP));
      queue_word(1'b0, enc_r(F7_BASE, 5'd31, 5'd1, F3_SLL, 5'd8, OPC_OP_IMM));
      queue_word(1'b0, enc_r(7'h01, 5'd3, 5'd1, F3_SLL, 5'd9, OPC_OP_IMM));
      queue_word(1'b0, enc_i(12'd5, 5'd1, F3_ADD, REG_ZERO, OPC_OP_IMM));
      queue_word(1'b0, enc_u(20'hFFFFF, 5'd9, OPC_AUIPC));
      queue_word(1'b0, enc_j(21'h1FFFFC, 5'd1));
      queue_word(1'b0, enc_i(12'd2, 5'd6, F3_ADD, 5'd13, OPC_JALR));
      queue_word(1'b0, enc_i(12'd0, 5'd6, 3'd1, 5'd13, OPC_JALR));
      queue_word(1'b0, enc_b(13'h0010, 5'd6, 5'd8, F3_BLT));
      queue_word(1'b0, enc_b(13'h0010, 5'd6, 5'd8, F3_BLTU));
      queue_word(1'b0, enc_b(13'h1FF0, 5'd8, 5'd6, F3_BGE));
      queue_word(1'b0, enc_b(13'h1FF0, 5'd8, 5'd6, F3_BGEU));
      queue_word(1'b0, enc_b(13'h1000, REG_ZERO, REG_ZERO, F3_BEQ));
      queue_word(1'b0, enc_b(13'h0FFE, REG_ZERO, 5'd6, F3_BNE));
      queue_word(1'b0, enc_b(13'h0008, 5'd6, 5'd6, 3'd2));
      queue_word(1'b0, enc_i(12'h7FF, 5'd2, 3'd2, 5'd14, OPC_LOAD));
      queue_word(1'b0, 32'h0010_0073);
      queue_word(1'b1, $urandom);
      queue_word(1'b0, ECALL_WORD);

      for (int k = 1; k <= 8; k++) begin
         wait_drained();
         quiet = (k == 3 || k == 6);
         apply_setting(k);
         settings_used++;
         @(negedge clock);
         queue_word(1'b1, $urandom);
         start = words_queued;
         while (words_queued - start < 250) begin
            case ($urandom_range(0, 99))
               0:       queue_word(1'b1, $urandom);
               1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15:
                        queue_call($urandom_range(0, 2));
               default: queue_word(1'b0, random_instr());
            endcase
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("Checked %0d results under %0d register settings.", results_seen, settings_used);
      $display("Coverage: %0d restarts, %0d prints, %0d host reads, %0d stops.",
               restart_count, print_count, read_count, stop_count);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/rvx_pkg.sv
rtl/rvx_ram.sv
rtl/rvx_front.sv
rtl/rvx_queue.sv
rtl/rvx_back.sv
rtl/rv32i_subset_execute_core.sv
rtl/rvx_checker.sv
dv/rv32i_subset_execute_core_tb.sv
